FILE: src/rvm_pkg.sv
// Shared constants and fixed-point helpers for the rotation vector to matrix unit.
// No dependencies.
package rvm_pkg;

    localparam int CORDIC_STEPS = 30;

    localparam logic signed [32:0] CORDIC_GAIN    = 33'sd652032874;
    localparam logic        [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic signed [31:0] HALF_PI_Q30    = 32'sd1686629713;
    localparam logic signed [33:0] Q30_ONE        = 34'sd1073741824;

    // quadrant codes of the phase
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    function automatic logic signed [31:0] atan_q30(input int unsigned i);
        logic signed [31:0] r;
        case (i)
            0:       r = 32'sd843314856;
            1:       r = 32'sd497837829;
            2:       r = 32'sd263043836;
            3:       r = 32'sd133525158;
            4:       r = 32'sd67021686;
            5:       r = 32'sd33543515;
            6:       r = 32'sd16775850;
            7:       r = 32'sd8388437;
            8:       r = 32'sd4194282;
            9:       r = 32'sd2097149;
            10:      r = 32'sd1048575;
            11:      r = 32'sd524287;
            12:      r = 32'sd262143;
            13:      r = 32'sd131071;
            14:      r = 32'sd65535;
            15:      r = 32'sd32767;
            16:      r = 32'sd16383;
            17:      r = 32'sd8191;
            18:      r = 32'sd4095;
            19:      r = 32'sd2047;
            20:      r = 32'sd1023;
            21:      r = 32'sd511;
            22:      r = 32'sd255;
            23:      r = 32'sd127;
            24:      r = 32'sd63;
            25:      r = 32'sd31;
            26:      r = 32'sd15;
            27:      r = 32'sd8;
            28:      r = 32'sd4;
            29:      r = 32'sd2;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    // arithmetic shift right, truncating toward zero
    function automatic logic signed [71:0] shr_tz(input logic signed [71:0] v,
                                                  input int unsigned n);
        logic signed [71:0] fl;
        logic        [71:0] msk;
        fl  = v >>> n;
        msk = (72'd1 << n) - 72'd1;
        if (v[71] && ((v & msk) != 72'd0)) begin
            fl = fl + 72'sd1;
        end
        return fl;
    endfunction

    // shift right, round to nearest, ties away from zero
    function automatic logic signed [71:0] shr_rnd(input logic signed [71:0] v,
                                                   input int unsigned n);
        logic signed [71:0] mag;
        mag = v[71] ? -v : v;
        if (n != 0) begin
            mag = (mag + (72'sd1 <<< (n - 1))) >>> n;
        end
        return v[71] ? -mag : mag;
    endfunction

    // Q30 entry to output field: round, clamp to +-one, clamp to 16 bits
    function automatic logic [15:0] to_field(input logic signed [71:0] v,
                                             input int unsigned sh,
                                             input logic signed [71:0] one);
        logic signed [71:0] r;
        r = shr_rnd(v, sh);
        if (r > one) begin
            r = one;
        end
        if (r < -one) begin
            r = -one;
        end
        if (r > 72'sd32767) begin
            r = 72'sd32767;
        end
        if (r < -72'sd32768) begin
            r = -72'sd32768;
        end
        return r[15:0];
    endfunction

endpackage

FILE: src/rvm_if.sv
// Valid/ready channels of the rotation vector to matrix unit: vector in, matrix out.
// No dependencies.
interface rvm_vec_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;

    modport source (output valid, rot_x, rot_y, rot_z, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

interface rvm_mat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

FILE: src/rotation_vector_to_matrix_unit.sv
// Rotation vector to rotation matrix (Rodrigues formula), fully pipelined.
// Depends on rvm_pkg and the channel interfaces in rvm_if.sv.
//
// Usage:
//   i_vec carries one rotation vector word (rot_x/y/z, signed, IN_FRAC_BITS
//   fraction bits, radians). o_mat carries the matching 3x3 rotation matrix word,
//   nine signed entries with OUT_FRAC_BITS fraction bits, row major, clamped to
//   +-1.0. Every vector word yields exactly one matrix word, in order.
//   A zero vector yields the identity matrix.
// Stages: 1 squaring stage, 31 square-root stages (one root bit each), 33
//   stages in which three restoring dividers (one quotient bit per stage) run
//   beside the phase reduction and 30 CORDIC stages, then 3 product/sum stages.
// Throughput: one word per clock while the output is not stalled (see Stall).
// Stall: the pipeline advances as a whole. While the output register holds a
//   word that o_mat does not take, every stage holds and i_vec.ready is low;
//   bubbles in the pipe still let new words in whenever the output stage is
//   empty or being taken.
// Reset: synchronous, active low; clears the valid bits only, so the pipe
//   comes out empty with i_vec.ready high.
module rotation_vector_to_matrix_unit #(
    parameter int IN_FRAC_BITS  = 12,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rvm_vec_if.sink    i_vec,
    rvm_mat_if.source  o_mat
);

    localparam int SQ_N  = 31;                       // root stages
    localparam int DV_N  = 32;                       // quotient bits
    localparam int CR_N  = rvm_pkg::CORDIC_STEPS;
    localparam int MID_N = CR_N + 3;                 // phase, residual, cordic, quadrant
    localparam int LAT   = 1 + SQ_N + MID_N + 3;
    localparam int PH_SH = IN_FRAC_BITS + 15;
    localparam int RND_SH = 30 - OUT_FRAC_BITS;
    localparam logic signed [71:0] ONE_Q = 72'sd1 <<< OUT_FRAC_BITS;

    logic           en;
    logic [LAT-1:0] r_vld;

    // pipe advances when the output stage is empty or being taken
    assign en          = !r_vld[LAT-1] || o_mat.ready;
    assign i_vec.ready = en;
    assign o_mat.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_vec.valid};
        end
    end

    // ---------------- stage 0: sum of squares ----------------
    logic [31:0] w_px, w_py, w_pz, w_sum;
    logic [15:0] w_mag [0:2];

    assign w_px  = 32'(i_vec.rot_x * i_vec.rot_x);
    assign w_py  = 32'(i_vec.rot_y * i_vec.rot_y);
    assign w_pz  = 32'(i_vec.rot_z * i_vec.rot_z);
    assign w_sum = w_px + w_py + w_pz;
    assign w_mag[0] = i_vec.rot_x[15] ? (~i_vec.rot_x + 16'd1) : i_vec.rot_x;
    assign w_mag[1] = i_vec.rot_y[15] ? (~i_vec.rot_y + 16'd1) : i_vec.rot_y;
    assign w_mag[2] = i_vec.rot_z[15] ? (~i_vec.rot_z + 16'd1) : i_vec.rot_z;

    logic [61:0] r_sq_n  [0:SQ_N-1];
    logic [61:0] r_sq_rt [0:SQ_N];
    logic [15:0] r_sq_mg [0:SQ_N][0:2];
    logic [2:0]  r_sq_sg [0:SQ_N];
    logic        r_sq_z  [0:SQ_N];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_n[0]  <= {w_sum, 30'd0};
            r_sq_rt[0] <= '0;
            r_sq_mg[0] <= w_mag;
            r_sq_sg[0] <= {i_vec.rot_z[15], i_vec.rot_y[15], i_vec.rot_x[15]};
            r_sq_z[0]  <= (w_sum == 32'd0);
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    for (genvar gk = 1; gk <= SQ_N; gk++) begin : g_sqrt
        localparam logic [62:0] BIT = 63'd1 << (2 * (SQ_N - gk));
        logic [62:0] w_try;
        logic [61:0] n_n, n_rt;

        always_comb begin
            w_try = {1'b0, r_sq_rt[gk-1]} + BIT;
            if ({1'b0, r_sq_n[gk-1]} >= w_try) begin
                n_n  = r_sq_n[gk-1] - w_try[61:0];
                n_rt = (r_sq_rt[gk-1] >> 1) + BIT[61:0];
            end else begin
                n_n  = r_sq_n[gk-1];
                n_rt = r_sq_rt[gk-1] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rt[gk] <= n_rt;
                r_sq_mg[gk] <= r_sq_mg[gk-1];
                r_sq_sg[gk] <= r_sq_sg[gk-1];
                r_sq_z[gk]  <= r_sq_z[gk-1];
            end
        end

        if (gk < SQ_N) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_n[gk] <= n_n;
                end
            end
        end
    end

    logic [30:0] w_theta;       // theta, IN_FRAC_BITS+15 fraction bits
    assign w_theta = r_sq_rt[SQ_N][30:0];

    // zero-vector flag through the middle section
    logic r_mz [1:MID_N];
    for (genvar gm = 1; gm <= MID_N; gm++) begin : g_mz
        if (gm == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_mz[gm] <= r_sq_z[SQ_N];
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_mz[gm] <= r_mz[gm-1];
                end
            end
        end
    end

    // ---------------- axis: three restoring dividers ----------------
    logic [60:0] r_dv_rem [1:DV_N-1][0:2];
    logic [31:0] r_dv_q   [1:DV_N][0:2];
    logic [30:0] r_dv_t   [1:DV_N-1];
    logic [2:0]  r_dv_sg  [1:DV_N];

    for (genvar gm = 1; gm <= DV_N; gm++) begin : g_div
        localparam int J = DV_N - gm;
        logic [60:0] w_rem_in [0:2];
        logic [31:0] w_q_in   [0:2];
        logic [30:0] w_t_in;
        logic [2:0]  w_sg_in;
        logic [60:0] n_rem    [0:2];
        logic [31:0] n_q      [0:2];

        if (gm == 1) begin : g_src
            for (genvar gl = 0; gl < 3; gl++) begin : g_l
                assign w_rem_in[gl] = {r_sq_mg[SQ_N][gl], 45'd0};
                assign w_q_in[gl]   = '0;
            end
            assign w_t_in  = w_theta;
            assign w_sg_in = r_sq_sg[SQ_N];
        end else begin : g_src
            assign w_rem_in = r_dv_rem[gm-1];
            assign w_q_in   = r_dv_q[gm-1];
            assign w_t_in   = r_dv_t[gm-1];
            assign w_sg_in  = r_dv_sg[gm-1];
        end

        for (genvar gl = 0; gl < 3; gl++) begin : g_lane
            logic [62:0] w_sub;
            always_comb begin
                w_sub = 63'(w_t_in) << J;
                if ({2'b00, w_rem_in[gl]} >= w_sub) begin
                    n_rem[gl] = w_rem_in[gl] - w_sub[60:0];
                    n_q[gl]   = w_q_in[gl] | (32'd1 << J);
                end else begin
                    n_rem[gl] = w_rem_in[gl];
                    n_q[gl]   = w_q_in[gl];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_q[gm]  <= n_q;
                r_dv_sg[gm] <= w_sg_in;
            end
        end

        if (gm < DV_N) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_rem[gm] <= n_rem;
                    r_dv_t[gm]   <= w_t_in;
                end
            end
        end
    end

    // signed axis in Q30, held one stage to line up with the CORDIC result
    logic signed [32:0] r_a [0:2];
    for (genvar gl = 0; gl < 3; gl++) begin : g_axis
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_a[gl] <= r_dv_sg[DV_N][gl] ? -{1'b0, r_dv_q[DV_N][gl]}
                                             :  {1'b0, r_dv_q[DV_N][gl]};
            end
        end
    end

    // ---------------- phase reduction ----------------
    logic [60:0] w_ph_prod;
    logic [67:0] w_ph_ext;
    logic [31:0] r_ph_p;        // phase in turns, Q32

    assign w_ph_prod = 61'(w_theta) * 61'(rvm_pkg::INV_TWO_PI_Q32);
    assign w_ph_ext  = 68'(w_ph_prod);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ph_p <= w_ph_ext[PH_SH +: 32];
        end
    end

    logic [31:0]        w_rs_sum, w_rs_d;
    logic [1:0]         w_rs_q;
    logic signed [63:0] w_rs_prod;
    logic signed [71:0] w_rs_rad;

    assign w_rs_sum  = r_ph_p + 32'h2000_0000;
    assign w_rs_q    = w_rs_sum[31:30];
    assign w_rs_d    = r_ph_p - {w_rs_q, 30'd0};
    assign w_rs_prod = 64'($signed(w_rs_d)) * 64'(rvm_pkg::HALF_PI_Q30);
    assign w_rs_rad  = rvm_pkg::shr_tz(72'(w_rs_prod), 30);

    // ---------------- CORDIC rotation ----------------
    logic signed [32:0] r_cx [2:CR_N+2];
    logic signed [32:0] r_cy [2:CR_N+2];
    logic signed [33:0] r_cz [2:CR_N+1];
    logic [1:0]         r_cq [2:CR_N+2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[2] <= rvm_pkg::CORDIC_GAIN;
            r_cy[2] <= '0;
            r_cz[2] <= w_rs_rad[33:0];
            r_cq[2] <= w_rs_q;
        end
    end

    for (genvar gm = 3; gm <= CR_N + 2; gm++) begin : g_cordic
        localparam int I = gm - 3;
        logic signed [71:0] w_xs, w_ys;
        logic signed [33:0] w_at;
        logic signed [32:0] n_x, n_y;
        logic signed [33:0] n_z;

        always_comb begin
            w_xs = rvm_pkg::shr_tz(72'(r_cx[gm-1]), I);
            w_ys = rvm_pkg::shr_tz(72'(r_cy[gm-1]), I);
            w_at = 34'(rvm_pkg::atan_q30(I));
            if (!r_cz[gm-1][33]) begin
                n_x = r_cx[gm-1] - w_ys[32:0];
                n_y = r_cy[gm-1] + w_xs[32:0];
                n_z = r_cz[gm-1] - w_at;
            end else begin
                n_x = r_cx[gm-1] + w_ys[32:0];
                n_y = r_cy[gm-1] - w_xs[32:0];
                n_z = r_cz[gm-1] + w_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cx[gm] <= n_x;
                r_cy[gm] <= n_y;
                r_cq[gm] <= r_cq[gm-1];
            end
        end

        if (gm <= CR_N + 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_cz[gm] <= n_z;
                end
            end
        end
    end

    // quadrant fold
    logic signed [32:0] n_c, n_s, r_c, r_s;
    always_comb begin
        case (r_cq[CR_N+2])
            rvm_pkg::QUAD_0: begin
                n_c = r_cx[CR_N+2];
                n_s = r_cy[CR_N+2];
            end
            rvm_pkg::QUAD_1: begin
                n_c = -r_cy[CR_N+2];
                n_s = r_cx[CR_N+2];
            end
            rvm_pkg::QUAD_2: begin
                n_c = -r_cx[CR_N+2];
                n_s = -r_cy[CR_N+2];
            end
            rvm_pkg::QUAD_3: begin
                n_c = r_cy[CR_N+2];
                n_s = -r_cx[CR_N+2];
            end
            default: begin
                n_c = r_cx[CR_N+2];
                n_s = r_cy[CR_N+2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c <= n_c;
            r_s <= n_s;
        end
    end

    // ---------------- F1: axis products and skew terms ----------------
    // pair order: 00 11 22 01 02 12
    localparam int PI_A [0:5] = '{0, 1, 2, 0, 0, 1};
    localparam int PI_B [0:5] = '{0, 1, 2, 1, 2, 2};

    logic signed [33:0] r_pa [0:5];
    logic signed [33:0] r_sk [0:2];
    logic signed [32:0] r_f1_c;
    logic signed [33:0] r_f1_omc;
    logic               r_f1_z;

    for (genvar gp = 0; gp < 6; gp++) begin : g_pa
        logic signed [65:0] w_prod;
        logic signed [71:0] w_tz;
        assign w_prod = 66'(r_a[PI_A[gp]]) * 66'(r_a[PI_B[gp]]);
        assign w_tz   = rvm_pkg::shr_tz(72'(w_prod), 30);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pa[gp] <= w_tz[33:0];
            end
        end
    end

    for (genvar gl = 0; gl < 3; gl++) begin : g_sk
        logic signed [65:0] w_prod;
        logic signed [71:0] w_tz;
        assign w_prod = 66'(r_s) * 66'(r_a[gl]);
        assign w_tz   = rvm_pkg::shr_tz(72'(w_prod), 30);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sk[gl] <= w_tz[33:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_c   <= r_c;
            r_f1_omc <= rvm_pkg::Q30_ONE - 34'(r_c);
            r_f1_z   <= r_mz[MID_N];
        end
    end

    // ---------------- F2: (1 - cos) * a a^T ----------------
    logic signed [35:0] r_aa [0:5];
    logic signed [33:0] r_f2_sk [0:2];
    logic signed [32:0] r_f2_c;
    logic               r_f2_z;

    for (genvar gp = 0; gp < 6; gp++) begin : g_aa
        logic signed [67:0] w_prod;
        logic signed [71:0] w_tz;
        assign w_prod = 68'(r_f1_omc) * 68'(r_pa[gp]);
        assign w_tz   = rvm_pkg::shr_tz(72'(w_prod), 30);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_aa[gp] <= w_tz[35:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f2_sk <= r_sk;
            r_f2_c  <= r_f1_c;
            r_f2_z  <= r_f1_z;
        end
    end

    // ---------------- F3: sum, round, clamp into the output register ----------------
    logic signed [35:0] w_m [0:8];
    logic [15:0]        r_m [0:8];

    always_comb begin
        w_m[0] = 36'(r_f2_c) + r_aa[0];
        w_m[4] = 36'(r_f2_c) + r_aa[1];
        w_m[8] = 36'(r_f2_c) + r_aa[2];
        w_m[1] = r_aa[3] - 36'(r_f2_sk[2]);
        w_m[3] = r_aa[3] + 36'(r_f2_sk[2]);
        w_m[2] = r_aa[4] + 36'(r_f2_sk[1]);
        w_m[6] = r_aa[4] - 36'(r_f2_sk[1]);
        w_m[5] = r_aa[5] - 36'(r_f2_sk[0]);
        w_m[7] = r_aa[5] + 36'(r_f2_sk[0]);
        if (r_f2_z) begin
            // zero vector: identity
            for (int e = 0; e < 9; e++) begin
                w_m[e] = (e % 4 == 0) ? 36'(rvm_pkg::Q30_ONE) : 36'sd0;
            end
        end
    end

    for (genvar ge = 0; ge < 9; ge++) begin : g_out
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_m[ge] <= rvm_pkg::to_field(72'(w_m[ge]), RND_SH, ONE_Q);
            end
        end
    end

    assign o_mat.m00 = r_m[0];
    assign o_mat.m01 = r_m[1];
    assign o_mat.m02 = r_m[2];
    assign o_mat.m10 = r_m[3];
    assign o_mat.m11 = r_m[4];
    assign o_mat.m12 = r_m[5];
    assign o_mat.m20 = r_m[6];
    assign o_mat.m21 = r_m[7];
    assign o_mat.m22 = r_m[8];

endmodule

FILE: src/rvm_checker.sv
// Port-level checks for the rotation vector to matrix unit, bound to the top level.
// Depends on rotation_vector_to_matrix_unit and its channel interfaces.
module rvm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_m00,
    input logic signed [15:0] i_m01,
    input logic signed [15:0] i_m11,
    input logic signed [15:0] i_m22
);

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output word valid right after reset");

    // a held output word stalls the whole pipe
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while output stalled");

    // empty output stage never blocks the input
    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output stage");

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_m00) && $stable(i_m01)))
        else $error("stalled output word changed");

    // diagonal entries never exceed one in magnitude (16384 at 14 fraction bits)
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_m00 <= 16'sd16384 && i_m00 >= -16'sd16384 &&
                         i_m11 <= 16'sd16384 && i_m11 >= -16'sd16384 &&
                         i_m22 <= 16'sd16384 && i_m22 >= -16'sd16384))
        else $error("diagonal entry out of range");

endmodule

bind rotation_vector_to_matrix_unit rvm_checker u_rvm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vec.valid),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_mat.valid),
    .i_out_ready (o_mat.ready),
    .i_m00       (o_mat.m00),
    .i_m01       (o_mat.m01),
    .i_m11       (o_mat.m11),
    .i_m22       (o_mat.m22)
);
